[hdl/toeq_pkg.sv]
// Shared types and constants for the time-ordered event queue.
// No dependencies; used by toeq_cell and time_ordered_event_queue.
package toeq_pkg;

  // Operation code carried by each input item
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  // Event type code width (fixed by the item format)
  localparam int unsigned TYPE_WIDTH = 2;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // insert accepted and queue not full
    logic pop;     // pop accepted
  } ctrl_t;

endpackage

[hdl/toeq_cell.sv]
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on toeq_pkg for the command struct and type width.
module toeq_cell #(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned ID_WIDTH   = 16,
  parameter bit          IS_HEAD    = 1'b0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  toeq_pkg::ctrl_t                 ctrl_i,
  input  logic [TIME_WIDTH-1:0]           new_time_i,
  input  logic [ID_WIDTH-1:0]             new_id_i,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] new_type_i,
  // left neighbor (toward the head)
  input  logic                            left_place_i,
  input  logic                            left_valid_i,
  input  logic [TIME_WIDTH-1:0]           left_time_i,
  input  logic [ID_WIDTH-1:0]             left_id_i,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] left_type_i,
  // right neighbor (toward the tail)
  input  logic                            right_valid_i,
  input  logic [TIME_WIDTH-1:0]           right_time_i,
  input  logic [ID_WIDTH-1:0]             right_id_i,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] right_type_i,
  // own state
  output logic                            place_o,
  output logic                            valid_o,
  output logic [TIME_WIDTH-1:0]           time_o,
  output logic [ID_WIDTH-1:0]             id_o,
  output logic [toeq_pkg::TYPE_WIDTH-1:0] type_o
);

  logic                            valid_q, valid_d;
  logic [TIME_WIDTH-1:0]           time_q, time_d;
  logic [ID_WIDTH-1:0]             id_q, id_d;
  logic [toeq_pkg::TYPE_WIDTH-1:0] type_q, type_d;
  logic                            later;

  // Head yields only to a strictly earlier entry; others yield on ties too
  assign later   = IS_HEAD ? (time_q > new_time_i) : (time_q >= new_time_i);
  // This slot lies at or behind the insert position
  assign place_o = !valid_q || later;

  // Next slot contents
  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    id_d    = id_q;
    type_d  = type_q;
    if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      time_d  = right_time_i;
      id_d    = right_id_i;
      type_d  = right_type_i;
    end else if (ctrl_i.insert && place_o) begin
      if (left_place_i) begin
        valid_d = left_valid_i;
        time_d  = left_time_i;
        id_d    = left_id_i;
        type_d  = left_type_i;
      end else begin
        valid_d = 1'b1;
        time_d  = new_time_i;
        id_d    = new_id_i;
        type_d  = new_type_i;
      end
    end
  end

  // Valid bit is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    id_q   <= id_d;
    type_q <= type_d;
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;
  assign id_o    = id_q;
  assign type_o  = type_q;

endmodule

[hdl/time_ordered_event_queue.sv]
// Time-ordered event queue: a chain of DEPTH slot cells, head in cell 0.
// Depends on toeq_pkg and toeq_cell.
// The result strobe done_o is registered and rises in the cycle after start is taken.
// Throughput: one item per cycle; every cell compares its key with the new
// key in parallel and shifts with its neighbor in the same cycle.
// busy stays low; the receiver cannot stall. Reset empties the queue at once.
module time_ordered_event_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned ID_WIDTH   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind_i,
  input  logic [TIME_WIDTH-1:0]           entry_time_i,
  input  logic [ID_WIDTH-1:0]             entry_id_i,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] entry_type_i,
  output logic                            done_o,
  output logic                            popped_valid_o,
  output logic [TIME_WIDTH-1:0]           popped_time_o,
  output logic [ID_WIDTH-1:0]             popped_id_o,
  output logic [toeq_pkg::TYPE_WIDTH-1:0] popped_type_o,
  output logic                            head_valid_o,
  output logic [TIME_WIDTH-1:0]           head_time_o,
  output logic [ID_WIDTH-1:0]             head_id_o,
  output logic [toeq_pkg::TYPE_WIDTH-1:0] head_type_o,
  output logic [$clog2(DEPTH+1)-1:0]      occupancy_o,
  output logic                            overflow_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned TyW  = toeq_pkg::TYPE_WIDTH;

  logic                  accept;
  logic                  is_pop;
  logic                  full;
  toeq_pkg::ctrl_t       ctrl;

  logic                  c_place [DEPTH];
  logic                  c_valid [DEPTH];
  logic [TIME_WIDTH-1:0] c_time  [DEPTH];
  logic [ID_WIDTH-1:0]   c_id    [DEPTH];
  logic [TyW-1:0]        c_type  [DEPTH];

  logic                  done_q;
  logic                  ovf_q, ovf_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pop_v_q, pop_v_d;
  logic [TIME_WIDTH-1:0] pop_time_q, pop_time_d;
  logic [ID_WIDTH-1:0]   pop_id_q, pop_id_d;
  logic [TyW-1:0]        pop_type_q, pop_type_d;

  // Command decode
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign is_pop      = (kind_i == toeq_pkg::KIND_POP);
  assign full        = c_valid[DEPTH-1];
  assign ctrl.insert = accept && !is_pop && !full;
  assign ctrl.pop    = accept && is_pop;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_place, l_valid, r_valid;
    logic [TIME_WIDTH-1:0] l_time, r_time;
    logic [ID_WIDTH-1:0]   l_id, r_id;
    logic [TyW-1:0]        l_type, r_type;

    if (i == 0) begin : g_first
      assign l_place = 1'b0;
      assign l_valid = 1'b0;
      assign l_time  = '0;
      assign l_id    = '0;
      assign l_type  = '0;
    end else begin : g_left
      assign l_place = c_place[i-1];
      assign l_valid = c_valid[i-1];
      assign l_time  = c_time[i-1];
      assign l_id    = c_id[i-1];
      assign l_type  = c_type[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_time  = '0;
      assign r_id    = '0;
      assign r_type  = '0;
    end else begin : g_right
      assign r_valid = c_valid[i+1];
      assign r_time  = c_time[i+1];
      assign r_id    = c_id[i+1];
      assign r_type  = c_type[i+1];
    end

    toeq_cell #(
      .TIME_WIDTH (TIME_WIDTH),
      .ID_WIDTH   (ID_WIDTH),
      .IS_HEAD    (i == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_time_i    (entry_time_i),
      .new_id_i      (entry_id_i),
      .new_type_i    (entry_type_i),
      .left_place_i  (l_place),
      .left_valid_i  (l_valid),
      .left_time_i   (l_time),
      .left_id_i     (l_id),
      .left_type_i   (l_type),
      .right_valid_i (r_valid),
      .right_time_i  (r_time),
      .right_id_i    (r_id),
      .right_type_i  (r_type),
      .place_o       (c_place[i]),
      .valid_o       (c_valid[i]),
      .time_o        (c_time[i]),
      .id_o          (c_id[i]),
      .type_o        (c_type[i])
    );
  end

  // Occupancy, overflow and popped item for the result
  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    pop_v_d    = pop_v_q;
    pop_time_d = pop_time_q;
    pop_id_d   = pop_id_q;
    pop_type_d = pop_type_q;
    if (accept) begin
      ovf_d      = !is_pop && full;
      pop_v_d    = is_pop && c_valid[0];
      pop_time_d = '0;
      pop_id_d   = '0;
      pop_type_d = '0;
      if (ctrl.insert) begin
        cnt_d = cnt_q + CntW'(1);
      end else if (pop_v_d) begin
        cnt_d      = cnt_q - CntW'(1);
        pop_time_d = c_time[0];
        pop_id_d   = c_id[0];
        pop_type_d = c_type[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pop_v_q <= 1'b0;
    end else begin
      done_q  <= accept;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pop_v_q <= pop_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_time_q <= pop_time_d;
    pop_id_q   <= pop_id_d;
    pop_type_q <= pop_type_d;
  end

  // Result ports; head reads the chain directly, zero when empty
  assign done_o         = done_q;
  assign popped_valid_o = pop_v_q;
  assign popped_time_o  = pop_time_q;
  assign popped_id_o    = pop_id_q;
  assign popped_type_o  = pop_type_q;
  assign head_valid_o   = c_valid[0];
  assign head_time_o    = c_valid[0] ? c_time[0] : '0;
  assign head_id_o      = c_valid[0] ? c_id[0] : '0;
  assign head_type_o    = c_valid[0] ? c_type[0] : '0;
  assign occupancy_o    = cnt_q;
  assign overflow_o     = ovf_q;

endmodule

[dv/toeq_checker.sv]
// Checker for the time-ordered event queue: predicts each status item and
// compares it with the block's output. Depends on toeq_pkg.
module toeq_checker #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned ID_WIDTH   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            kind_i,
  input  logic [TIME_WIDTH-1:0]           entry_time_i,
  input  logic [ID_WIDTH-1:0]             entry_id_i,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] entry_type_i,
  input  logic                            done_o,
  input  logic                            popped_valid_o,
  input  logic [TIME_WIDTH-1:0]           popped_time_o,
  input  logic [ID_WIDTH-1:0]             popped_id_o,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] popped_type_o,
  input  logic                            head_valid_o,
  input  logic [TIME_WIDTH-1:0]           head_time_o,
  input  logic [ID_WIDTH-1:0]             head_id_o,
  input  logic [toeq_pkg::TYPE_WIDTH-1:0] head_type_o,
  input  logic [$clog2(DEPTH+1)-1:0]      occupancy_o,
  input  logic                            overflow_o,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OCC_WIDTH = $clog2(DEPTH + 1);
  localparam int unsigned TYPE_WIDTH = toeq_pkg::TYPE_WIDTH;

  // One status item as the block reports it
  typedef struct packed {
    logic                  popped_valid;
    logic [TIME_WIDTH-1:0] popped_time;
    logic [ID_WIDTH-1:0]   popped_id;
    logic [TYPE_WIDTH-1:0] popped_type;
    logic                  head_valid;
    logic [TIME_WIDTH-1:0] head_time;
    logic [ID_WIDTH-1:0]   head_id;
    logic [TYPE_WIDTH-1:0] head_type;
    logic [OCC_WIDTH-1:0]  occupancy;
    logic                  overflow;
  } queue_status_t;

  // Shadow copy of the sorted queue, slot 0 is the head
  logic [TIME_WIDTH-1:0] shadow_key  [DEPTH];
  logic [ID_WIDTH-1:0]   shadow_id   [DEPTH];
  logic [TYPE_WIDTH-1:0] shadow_type [DEPTH];
  int unsigned           shadow_count;

  queue_status_t status_q[$];

  // Apply one insert or pop to the shadow queue and build the status it gives
  task automatic apply_event(input toeq_pkg::kind_e k,
                             input logic [TIME_WIDTH-1:0] key,
                             input logic [ID_WIDTH-1:0] id,
                             input logic [TYPE_WIDTH-1:0] ty,
                             output queue_status_t st);
    int unsigned pos;
    int unsigned i;
    st = '0;
    if (k == toeq_pkg::KIND_INSERT) begin
      if (shadow_count >= DEPTH) begin
        st.overflow = 1'b1;
      end else begin
        // ties with the head go behind it, ahead of later equal keys
        if (shadow_count == 0 || shadow_key[0] > key) begin
          pos = 0;
        end else begin
          pos = shadow_count;
          for (i = 1; i < shadow_count; i++) begin
            if (shadow_key[i] >= key) begin
              pos = i;
              break;
            end
          end
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_key[i]  = shadow_key[i-1];
          shadow_id[i]   = shadow_id[i-1];
          shadow_type[i] = shadow_type[i-1];
        end
        shadow_key[pos]  = key;
        shadow_id[pos]   = id;
        shadow_type[pos] = ty;
        shadow_count++;
      end
    end else if (shadow_count > 0) begin
      st.popped_valid = 1'b1;
      st.popped_time  = shadow_key[0];
      st.popped_id    = shadow_id[0];
      st.popped_type  = shadow_type[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_key[i-1]  = shadow_key[i];
        shadow_id[i-1]   = shadow_id[i];
        shadow_type[i-1] = shadow_type[i];
      end
      shadow_count--;
    end
    if (shadow_count > 0) begin
      st.head_valid = 1'b1;
      st.head_time  = shadow_key[0];
      st.head_id    = shadow_id[0];
      st.head_type  = shadow_type[0];
    end
    st.occupancy = OCC_WIDTH'(shadow_count);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // Predict on every accepted item, compare on every strobe
  always @(posedge clk_i or negedge rst_ni) begin
    queue_status_t st;
    queue_status_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      status_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (start && !busy) begin
        apply_event(toeq_pkg::kind_e'(kind_i), entry_time_i, entry_id_i, entry_type_i,
                    st);
        status_q.push_back(st);
      end
      if (done_o) begin
        if (status_q.size() == 0) begin
          $error("status item with none expected");
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("popped_valid", want.popped_valid, popped_valid_o);
          check_field("popped_time", want.popped_time, popped_time_o);
          check_field("popped_id", want.popped_id, popped_id_o);
          check_field("popped_type", want.popped_type, popped_type_o);
          check_field("head_valid", want.head_valid, head_valid_o);
          check_field("head_time", want.head_time, head_time_o);
          check_field("head_id", want.head_id, head_id_o);
          check_field("head_type", want.head_type, head_type_o);
          check_field("occupancy", want.occupancy, occupancy_o);
          check_field("overflow", want.overflow, overflow_o);
        end
      end
      pending_o <= status_q.size();
    end
  end

endmodule

[dv/tb_time_ordered_event_queue.sv]
// Testbench top for the time-ordered event queue: clock, reset, insert/pop
// stimulus and verdict. Depends on toeq_pkg, the RTL and toeq_checker.
module tb_time_ordered_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned ID_WIDTH   = 16;
  localparam int unsigned TYPE_WIDTH = toeq_pkg::TYPE_WIDTH;
  localparam int unsigned OCC_WIDTH  = $clog2(DEPTH + 1);
  localparam int          STALL_LIMIT = 200;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          QUIET_TAIL   = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  kind_i;
  logic [TIME_WIDTH-1:0] entry_time_i;
  logic [ID_WIDTH-1:0]   entry_id_i;
  logic [TYPE_WIDTH-1:0] entry_type_i;
  logic                  done_o;
  logic                  popped_valid_o;
  logic [TIME_WIDTH-1:0] popped_time_o;
  logic [ID_WIDTH-1:0]   popped_id_o;
  logic [TYPE_WIDTH-1:0] popped_type_o;
  logic                  head_valid_o;
  logic [TIME_WIDTH-1:0] head_time_o;
  logic [ID_WIDTH-1:0]   head_id_o;
  logic [TYPE_WIDTH-1:0] head_type_o;
  logic [OCC_WIDTH-1:0]  occupancy_o;
  logic                  overflow_o;

  int fail_count;
  int pending_count;
  int stall_cycles;
  bit gaps_on;

  time_ordered_event_queue #(
    .DEPTH(DEPTH), .TIME_WIDTH(TIME_WIDTH), .ID_WIDTH(ID_WIDTH)
  ) DUT (.*);

  toeq_checker #(
    .DEPTH(DEPTH), .TIME_WIDTH(TIME_WIDTH), .ID_WIDTH(ID_WIDTH)
  ) u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: too long without any item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Present one item, with an optional idle burst before it
  task automatic issue_event(input toeq_pkg::kind_e k, input logic [TIME_WIDTH-1:0] key,
                             input logic [ID_WIDTH-1:0] id,
                             input logic [TYPE_WIDTH-1:0] ty);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= k;
    entry_time_i <= key;
    entry_id_i   <= id;
    entry_type_i <= ty;
    do @(posedge clk_i); while (busy);
  endtask

  // Keys: narrow range for many ties, extremes, and full range
  function automatic logic [TIME_WIDTH-1:0] pick_key();
    logic [TIME_WIDTH-1:0] key;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: key = TIME_WIDTH'($urandom_range(0, 15));
      4:          key = '0;
      5:          key = '1;
      6:          key = '1 - TIME_WIDTH'($urandom_range(0, 15));
      default:    key = TIME_WIDTH'($urandom);
    endcase
    return key;
  endfunction

  initial begin
    int insert_pct;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    kind_i       <= toeq_pkg::KIND_INSERT;
    entry_time_i <= '0;
    entry_id_i   <= '0;
    entry_type_i <= '0;
    gaps_on       = 1'b1;
    insert_pct    = 50;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty pop, ties around the head, extremes, full, overflow
    issue_event(toeq_pkg::KIND_POP, '1, '1, '1);
    issue_event(toeq_pkg::KIND_INSERT, 100, 1, 1);
    issue_event(toeq_pkg::KIND_INSERT, 100, 2, 2);
    issue_event(toeq_pkg::KIND_INSERT, 100, 3, 3);
    issue_event(toeq_pkg::KIND_INSERT, 50, 4, 0);
    issue_event(toeq_pkg::KIND_INSERT, '0, '0, '0);
    issue_event(toeq_pkg::KIND_INSERT, '1, '1, '1);
    issue_event(toeq_pkg::KIND_INSERT, '1, 5, 1);
    repeat (9) issue_event(toeq_pkg::KIND_INSERT, pick_key(), ID_WIDTH'($urandom),
                           TYPE_WIDTH'($urandom));
    issue_event(toeq_pkg::KIND_INSERT, '0, 16'h00aa, 2);
    repeat (4) issue_event(toeq_pkg::KIND_POP, TIME_WIDTH'($urandom), '0, '0);

    // Random: phases with different insert rates sweep the fill level
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 10;
          1:       insert_pct = 40;
          2:       insert_pct = 60;
          default: insert_pct = 90;
        endcase
      end
      gaps_on = (n < RANDOM_ITEMS - QUIET_TAIL);
      if ($urandom_range(0, 99) < insert_pct)
        issue_event(toeq_pkg::KIND_INSERT, pick_key(), ID_WIDTH'($urandom),
                    TYPE_WIDTH'($urandom));
      else
        issue_event(toeq_pkg::KIND_POP, TIME_WIDTH'($urandom), ID_WIDTH'($urandom),
                    TYPE_WIDTH'($urandom));
    end
    start <= 1'b0;

    // Drain: all status items back, then a few quiet cycles
    do @(posedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
